// ----- design/pwzc_pkg.sv -----
// Shared types, codes and helpers for the pilot-wire zone controller.
package pwzc_pkg;

  localparam int unsigned MaxZones   = 8;
  localparam int unsigned CfgWidth   = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned DefZones   = 4;
  localparam int unsigned DefCountW  = 32;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_APPLY   = 3'd1,
    CMD_START   = 3'd2,
    CMD_END     = 3'd3,
    CMD_LOCK    = 3'd4,
    CMD_UNLOCK  = 3'd5,
    CMD_RSVD6   = 3'd6,
    CMD_RSVD7   = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_NORMAL   = 3'd1,
    ST_OVERRIDE = 3'd2,
    ST_RESTORE  = 3'd3,
    ST_LOCKED   = 3'd4
  } zone_state_e;

  localparam logic [2:0] ModeEco     = 3'd0;
  localparam logic [2:0] ModeComfort = 3'd1;
  localparam logic [2:0] ModeFrost   = 3'd2;
  localparam logic [2:0] ModeStop    = 3'd3;
  localparam logic [2:0] ModeCm2     = 3'd4;

  typedef enum logic [2:0] {
    REG_CM2_ON    = 3'd0,
    REG_CM2_OFF   = 3'd1,
    REG_FALLBACK  = 3'd2,
    REG_RESTORE   = 3'd3,
    REG_DEF_PRIO  = 3'd4,
    REG_OVL_PRIO  = 3'd5,
    REG_FLT_PRIO  = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_e;

  localparam logic [31:0] RstCm2On    = 32'd7000;
  localparam logic [31:0] RstCm2Off   = 32'd293000;
  localparam logic [31:0] RstFallback = 32'd1800000;
  localparam logic [31:0] RstRestore  = 32'd2000;
  localparam logic [2:0]  RstDefPrio  = 3'd0;
  localparam logic [2:0]  RstOvlPrio  = 3'd2;
  localparam logic [2:0]  RstFltPrio  = 3'd7;

  // configuration seen by every zone
  typedef struct packed {
    logic [31:0] cm2_on;
    logic [31:0] cm2_off;
    logic [31:0] fallback;
    logic [31:0] restore;
    logic [2:0]  def_prio;
    logic [2:0]  ovl_prio;
    logic [2:0]  flt_prio;
  } cfg_t;

  // decoded event as seen by one zone
  typedef struct packed {
    logic       tick;
    logic       apply;
    logic       start;
    logic       stop;
    logic       lock;
    logic       unlock;
    logic [2:0] heat_mode;
    logic [2:0] prio;
    logic       ovl;
  } zone_evt_t;

  // drive pair for a mode: {pos, neg}
  function automatic logic [1:0] mode_drive(input logic [2:0] mode);
    logic [1:0] r;
    r = 2'b00;
    if (mode == ModeComfort) r = 2'b11;
    else if (mode == ModeFrost) r = 2'b10;
    else if (mode == ModeStop) r = 2'b01;
    return r;
  endfunction

endpackage

// ----- design/pwzc_stream_if.sv -----
// Valid/ready stream interface with a generic payload.
interface pwzc_stream_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/pwzc_cfg_regs.sv -----
// Configuration register file.
module pwzc_cfg_regs import pwzc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cm2_on   <= RstCm2On;
      cfg_q.cm2_off  <= RstCm2Off;
      cfg_q.fallback <= RstFallback;
      cfg_q.restore  <= RstRestore;
      cfg_q.def_prio <= RstDefPrio;
      cfg_q.ovl_prio <= RstOvlPrio;
      cfg_q.flt_prio <= RstFltPrio;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CM2_ON:   cfg_q.cm2_on   <= cfg_data_i;
        REG_CM2_OFF:  cfg_q.cm2_off  <= cfg_data_i;
        REG_FALLBACK: cfg_q.fallback <= cfg_data_i;
        REG_RESTORE:  cfg_q.restore  <= cfg_data_i;
        REG_DEF_PRIO: cfg_q.def_prio <= cfg_data_i[2:0];
        REG_OVL_PRIO: cfg_q.ovl_prio <= cfg_data_i[2:0];
        REG_FLT_PRIO: cfg_q.flt_prio <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/pwzc_zone.sv -----
// State, counters and drive levels of one heating zone.
module pwzc_zone import pwzc_pkg::*; #(
  parameter int unsigned CountWidth = DefCountW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  zone_evt_t   evt_i,
  input  cfg_t        cfg_i,
  output logic        acc_o,
  output zone_state_e state_d_o,
  output logic        pos_o,
  output logic        neg_o
);

  localparam logic [CountWidth-1:0] CntMax = '1;

  zone_state_e           st_q, st_d;
  logic [2:0]            cur_q, cur_d, sav_q, sav_d, lvl_q, lvl_d;
  logic                  run_q, run_d, off_q, off_d, pos_q, pos_d, neg_q, neg_d;
  logic [CountWidth-1:0] ph_q, ph_d, ov_q, ov_d, rs_q, rs_d;
  logic [CountWidth-1:0] ph_inc, ov_inc, rs_inc;
  logic [1:0]            drv;
  logic                  acc;

  assign ph_inc = (ph_q == CntMax) ? CntMax : ph_q + 1'b1;
  assign ov_inc = (ov_q == CntMax) ? CntMax : ov_q + 1'b1;
  assign rs_inc = (rs_q == CntMax) ? CntMax : rs_q + 1'b1;

  // next-state logic for this zone
  always_comb begin
    st_d = st_q; cur_d = cur_q; sav_d = sav_q; lvl_d = lvl_q;
    run_d = run_q; off_d = off_q; pos_d = pos_q; neg_d = neg_q;
    ph_d = ph_q; ov_d = ov_q; rs_d = rs_q;
    acc = 1'b0;
    drv = 2'b00;
    if (evt_i.tick) begin
      // cm2 cycle runs in normal and override
      if (run_q && (st_q == ST_NORMAL || st_q == ST_OVERRIDE)) begin
        ph_d = ph_inc;
        if (!off_q && {32'd0, ph_inc} >= {{CountWidth{1'b0}}, cfg_i.cm2_on}) begin
          off_d = 1'b1; ph_d = '0; pos_d = 1'b0; neg_d = 1'b0;
        end else if (off_q && {32'd0, ph_inc} >= {{CountWidth{1'b0}}, cfg_i.cm2_off}) begin
          off_d = 1'b0; ph_d = '0; pos_d = 1'b1; neg_d = 1'b1;
        end
      end
      unique case (st_q)
        ST_OVERRIDE: begin
          ov_d = ov_inc;
          if ({32'd0, ov_inc} >= {{CountWidth{1'b0}}, cfg_i.fallback}) begin
            st_d = ST_RESTORE; rs_d = '0;
          end
        end
        ST_RESTORE: begin
          rs_d = rs_inc;
          if ({32'd0, rs_inc} >= {{CountWidth{1'b0}}, cfg_i.restore}) begin
            cur_d = sav_q; lvl_d = cfg_i.def_prio; st_d = ST_NORMAL; run_d = 1'b0;
            drv = mode_drive(sav_q); pos_d = drv[1]; neg_d = drv[0];
          end
        end
        ST_LOCKED: begin
          if (cur_q != ModeEco) begin
            cur_d = ModeEco; pos_d = 1'b0; neg_d = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (evt_i.lock) begin
      st_d = ST_LOCKED; run_d = 1'b0; pos_d = 1'b0; neg_d = 1'b0;
    end else if (evt_i.unlock) begin
      st_d = ST_NORMAL; lvl_d = cfg_i.def_prio;
    end else if (en_i && evt_i.apply) begin
      if (!(st_q == ST_LOCKED && evt_i.prio != cfg_i.flt_prio) && evt_i.prio >= lvl_q) begin
        acc = 1'b1;
        if (evt_i.ovl && st_q == ST_NORMAL) begin
          sav_d = cur_q; st_d = ST_OVERRIDE; ov_d = '0;
        end else if (st_q == ST_IDLE || st_q == ST_RESTORE) begin
          st_d = ST_NORMAL;
        end
        cur_d = evt_i.heat_mode; lvl_d = evt_i.prio;
        if (evt_i.heat_mode == ModeCm2) begin
          run_d = 1'b1; off_d = 1'b0; ph_d = '0; pos_d = 1'b1; neg_d = 1'b1;
        end else begin
          run_d = 1'b0;
          drv = mode_drive(evt_i.heat_mode); pos_d = drv[1]; neg_d = drv[0];
        end
      end
    end else if (en_i && evt_i.start) begin
      if (st_q != ST_OVERRIDE) begin
        sav_d = cur_q; st_d = ST_OVERRIDE; ov_d = '0; run_d = 1'b0;
        drv = mode_drive(evt_i.heat_mode); pos_d = drv[1]; neg_d = drv[0];
        cur_d = evt_i.heat_mode; lvl_d = cfg_i.ovl_prio;
      end
    end else if (en_i && evt_i.stop) begin
      if (st_q == ST_OVERRIDE) begin
        st_d = ST_RESTORE; rs_d = '0;
      end
    end
  end

  // zone registers; the gated event vector makes this idle-safe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cur_q <= ModeEco; sav_q <= ModeEco; lvl_q <= RstDefPrio;
      run_q <= 1'b0; off_q <= 1'b0; pos_q <= 1'b0; neg_q <= 1'b0;
      ph_q <= '0; ov_q <= '0; rs_q <= '0;
    end else begin
      st_q <= st_d; cur_q <= cur_d; sav_q <= sav_d; lvl_q <= lvl_d;
      run_q <= run_d; off_q <= off_d; pos_q <= pos_d; neg_q <= neg_d;
      ph_q <= ph_d; ov_q <= ov_d; rs_q <= rs_d;
    end
  end

  assign acc_o     = acc;
  assign state_d_o = st_d;
  assign pos_o     = pos_d;
  assign neg_o     = neg_d;

endmodule

// ----- design/pilot_wire_zone_controller.sv -----
// Top level of the pilot-wire zone controller.
// Takes one event word per cycle (tick, apply, override start/end, lock,
// unlock) and returns one result word per event. All zones update in parallel
// in a single pass, and the result is held in an output register with a
// one-deep skid stage, so input is taken every cycle while the output side
// keeps up. Reset values of the configuration registers match the default
// timings; no clearing pass is needed after reset.
module pilot_wire_zone_controller import pwzc_pkg::*; #(
  parameter int unsigned ZoneCount  = DefZones,
  parameter int unsigned CountWidth = DefCountW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pwzc_stream_if.sink         in_if,
  pwzc_stream_if.source       out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  // input word: {cmd, zone, heat_mode, priority_req, from_overload}
  logic [2:0] cmd, zn, mode, prio;
  logic       ovl, valid_zone, fire;
  logic [2:0] zidx;
  cfg_t       cfg;
  zone_evt_t  evt;
  cmd_e       cmd_c;

  logic [ZoneCount-1:0] acc_v, pos_v, neg_v;
  zone_state_e          st_v [ZoneCount];

  assign {cmd, zn, mode, prio, ovl} = in_if.data;
  assign cmd_c      = cmd_e'(cmd);
  assign valid_zone = (zn >= 3'd1) && ({29'd0, zn} <= 32'(ZoneCount));
  assign zidx       = zn - 3'd1;

  pwzc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  // output register plus skid slot
  logic        out_v_q, skid_v_q;
  logic [19:0] out_q, skid_q, res_d;

  assign in_if.ready = !skid_v_q;
  assign fire        = in_if.valid && in_if.ready;

  // decode into an event broadcast to all zones
  always_comb begin
    evt           = '0;
    evt.heat_mode = mode;
    evt.prio      = prio;
    evt.ovl       = ovl;
    if (fire) begin
      unique case (cmd_c)
        CMD_TICK:   evt.tick   = 1'b1;
        CMD_APPLY:  evt.apply  = 1'b1;
        CMD_START:  evt.start  = 1'b1;
        CMD_END:    evt.stop   = 1'b1;
        CMD_LOCK:   evt.lock   = 1'b1;
        CMD_UNLOCK: evt.unlock = 1'b1;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < ZoneCount; g++) begin : g_zone
    pwzc_zone #(.CountWidth(CountWidth)) u_zone (
      .clk_i, .rst_ni,
      .en_i(valid_zone && (zidx == 3'(g))),
      .evt_i(evt), .cfg_i(cfg),
      .acc_o(acc_v[g]), .state_d_o(st_v[g]), .pos_o(pos_v[g]), .neg_o(neg_v[g])
    );
  end

  // result word: {accepted, pos_lines, neg_lines, zone_status}
  always_comb begin
    logic [7:0] pl, nl;
    logic [2:0] zs;
    pl = '0; nl = '0; zs = 3'd0;
    pl[ZoneCount-1:0] = pos_v;
    nl[ZoneCount-1:0] = neg_v;
    for (int i = 0; i < ZoneCount; i++) begin
      if (valid_zone && zidx == 3'(i)) zs = st_v[i];
    end
    res_d = {|acc_v, pl, nl, zs};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || out_if.ready) begin
        out_v_q  <= skid_v_q || fire;
        skid_v_q <= 1'b0;
      end else if (fire) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_if.ready) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end
    if (fire) skid_q <= res_d;
  end

  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;

`ifndef SYNTH
  a_skid_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid word without output word");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && out_v_q && !out_if.ready) |=> skid_v_q) else $error("word dropped");
  a_accept_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|acc_v) |-> (fire && cmd_c == CMD_APPLY)) else $error("stray accept");
  a_one_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(acc_v)) else $error("multiple zones accepted");
`endif

endmodule
